[hdl/icgf_pkg.sv]
// icgf_pkg: shared types and codes for the interval complement gap filler
// no dependencies; used by the channel interfaces, the top level and the checker
`default_nettype none

package icgf_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic {
    OP_INTERVAL = 1'b0,
    OP_FINISH   = 1'b1
  } opcode_t;

  typedef enum logic [StatusW-1:0] {
    ST_FILL   = 2'd0,
    ST_BEYOND = 2'd1,
    ST_ORDER  = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REGION_OFFSET = 2'd0,
    REG_REGION_LENGTH = 2'd1,
    REG_ORIGIN_ONE    = 2'd2,
    REG_FILL_VALUE    = 2'd3
  } cfg_idx_t;

  // one result request as held in the output register
  typedef struct packed {
    coord_t  fill_begin;
    coord_t  fill_end;
    coord_t  fill_data;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

[hdl/icgf_ifs.sv]
// icgf channel interfaces: interval input, fill-range output, config write
// depends on icgf_pkg
`default_nettype none

interface icgf_in_if
  import icgf_pkg::*;
();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  coord_t  interval_start;
  coord_t  interval_end;
  logic    value_is_zero;

  modport source (output valid, opcode, interval_start, interval_end, value_is_zero,
                  input ready);
  modport sink   (input valid, opcode, interval_start, interval_end, value_is_zero,
                  output ready);
endinterface

interface icgf_out_if
  import icgf_pkg::*;
();
  logic    valid;
  logic    ready;
  coord_t  fill_begin;
  coord_t  fill_end;
  coord_t  fill_data;
  status_t status;

  modport source (output valid, fill_begin, fill_end, fill_data, status, input ready);
  modport sink   (input valid, fill_begin, fill_end, fill_data, status, output ready);
endinterface

interface icgf_cfg_if
  import icgf_pkg::*;
();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coord_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/interval_complement_gap_filler.sv]
// interval_complement_gap_filler: turns sorted intervals into gap fill-range requests
// an input request passes the input reg, then the result reg, before its result request
// throughput: one request per cycle while results are taken, the running-end update is combinational
// a stalled result does not block the input register while it has no result to give
// reset: rst_n synchronous active low, clears valids, running end and config regs
// depends on icgf_pkg and the interfaces in icgf_ifs.sv
`default_nettype none

module interval_complement_gap_filler
  import icgf_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  icgf_in_if.sink     in_req,
  icgf_out_if.source  out_req,
  icgf_cfg_if.sink    cfg_req
);

  // configuration registers
  coord_t region_offset_r;
  coord_t region_length_r;
  logic   origin_one_r;
  coord_t fill_value_r;

  // input register stage
  logic    s1_valid_r;
  opcode_t s1_opcode_r;
  coord_t  s1_start_r;
  coord_t  s1_end_r;
  logic    s1_zero_r;

  // running end of the last accepted interval
  coord_t running_end_r;
  coord_t running_end_nxt;

  // result register stage
  logic    out_valid_r;
  result_t out_res_r;

  // stage 1 combinational results
  logic    s1_has_res;
  result_t s1_res;
  logic    s1_go;
  logic    in_fire;

  coord_t  s_adj;
  coord_t  b_val;
  coord_t  en_val;
  coord_t  en_shift;
  logic    drop;
  logic    beyond;

  // config port never stalls; the user must write only while idle, the block does not enforce it
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_offset_r <= '0;
      region_length_r <= '0;
      origin_one_r    <= 1'b0;
      fill_value_r    <= '0;
    end else if (cfg_req.valid) begin
      unique case (cfg_req.index)
        REG_REGION_OFFSET: region_offset_r <= cfg_req.data;
        REG_REGION_LENGTH: region_length_r <= cfg_req.data;
        REG_ORIGIN_ONE:    origin_one_r    <= cfg_req.data[0];
        REG_FILL_VALUE:    fill_value_r    <= cfg_req.data;
      endcase
    end
  end

  // stage 1 leaves when it has no result or the result register can take one
  assign s1_go   = !s1_has_res || !out_valid_r || out_req.ready;
  assign in_req.ready = !s1_valid_r || s1_go;
  assign in_fire = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_req.opcode;
      s1_start_r  <= in_req.interval_start;
      s1_end_r    <= in_req.interval_end;
      s1_zero_r   <= in_req.value_is_zero;
    end
  end

  // interval clipping against the region
  always_comb begin
    // origin-one start of zero stays zero
    s_adj = (origin_one_r && (s1_start_r != '0)) ? s1_start_r - coord_t'(1) : s1_start_r;
    en_shift = s1_end_r - region_offset_r;
    drop   = 1'b0;
    beyond = 1'b0;
    if (region_offset_r == '0) begin
      // reject-beyond-end mode, no clipping
      beyond = (s1_end_r > region_length_r);
      b_val  = s_adj;
      en_val = s1_end_r;
    end else begin
      b_val  = (s_adj <= region_offset_r) ? '0 : s_adj - region_offset_r;
      drop   = (s1_end_r <= region_offset_r) || (b_val >= region_length_r);
      en_val = (en_shift >= region_length_r) ? region_length_r : en_shift;
    end
  end

  // result selection and running end update
  always_comb begin
    s1_has_res      = 1'b0;
    s1_res          = '{fill_begin: '0, fill_end: '0, fill_data: '0, status: ST_FILL};
    running_end_nxt = running_end_r;
    if (s1_valid_r) begin
      if (s1_opcode_r == OP_FINISH) begin
        // tail gap up to the region end, then start a fresh region
        running_end_nxt = '0;
        if (running_end_r < region_length_r) begin
          s1_has_res = 1'b1;
          s1_res     = '{fill_begin: running_end_r, fill_end: region_length_r,
                         fill_data: fill_value_r, status: ST_FILL};
        end
      end else if (!s1_zero_r) begin
        if (beyond) begin
          s1_has_res    = 1'b1;
          s1_res.status = ST_BEYOND;
        end else if (!drop) begin
          if (b_val < running_end_r) begin
            s1_has_res    = 1'b1;
            s1_res.status = ST_ORDER;
          end else begin
            running_end_nxt = en_val;
            // empty gaps give nothing but still move the running end
            if (running_end_r < b_val) begin
              s1_has_res = 1'b1;
              s1_res     = '{fill_begin: running_end_r, fill_end: b_val,
                             fill_data: fill_value_r, status: ST_FILL};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_end_r <= '0;
    end else if (s1_valid_r && s1_go) begin
      running_end_r <= running_end_nxt;
    end
  end

  // result register: loads on a leaving item with a result, clears on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_has_res && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_has_res && s1_go) begin
      out_res_r <= s1_res;
    end
  end

  assign out_req.valid      = out_valid_r;
  assign out_req.fill_begin = out_res_r.fill_begin;
  assign out_req.fill_end   = out_res_r.fill_end;
  assign out_req.fill_data  = out_res_r.fill_data;
  assign out_req.status     = out_res_r.status;

endmodule

`default_nettype wire

[hdl/icgf_checker.sv]
// icgf_checker: port-level assertions on the gap filler's result channel
// depends on icgf_pkg; bound to interval_complement_gap_filler below
`default_nettype none

module icgf_checker
  import icgf_pkg::*;
(
  input wire     clk,
  input wire     rst_n,
  input wire     out_valid,
  input wire     out_ready,
  input coord_t  out_fill_begin,
  input coord_t  out_fill_end,
  input coord_t  out_fill_data,
  input status_t out_status
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_fill_begin) && $stable(out_fill_end)
      && $stable(out_fill_data) && $stable(out_status))
    else $error("stalled result changed");

  // a gap is never empty
  a_gap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FILL |-> out_fill_begin < out_fill_end)
    else $error("empty gap issued");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BEYOND || out_status == ST_ORDER)
      |-> out_fill_begin == '0 && out_fill_end == '0 && out_fill_data == '0)
    else $error("error result with nonzero fields");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind interval_complement_gap_filler icgf_checker u_icgf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_req.valid),
  .out_ready      (out_req.ready),
  .out_fill_begin (out_req.fill_begin),
  .out_fill_end   (out_req.fill_end),
  .out_fill_data  (out_req.fill_data),
  .out_status     (out_req.status)
);

`default_nettype wire

[verif/interval_complement_gap_filler_tb.sv]
// interval_complement_gap_filler_tb: self-checking bench for the interval gap filler
// drives interval and finish requests plus register writes, checks every fill-range result
// depends on icgf_pkg, the channels in icgf_ifs.sv and interval_complement_gap_filler

module interval_complement_gap_filler_tb;
  import icgf_pkg::*;

  // quiet cycles (nothing moving on any channel) before the run is declared hung
  localparam int QuietLimit  = 1000;
  // two-stage pipe plus margin, so a request with no result has left the block
  localparam int DrainCycles = 8;
  // one long result hold-off, long enough to back the input up
  localparam int HoldCycles  = 80;
  // random requests per idle mix
  localparam int PhaseItems  = 140;
  localparam int MaxGap      = 40;

  localparam coord_t Ones = '1;

  typedef enum logic {
    ROW_CFG  = 1'b0,
    ROW_ITEM = 1'b1
  } row_kind_t;

  typedef struct packed {
    opcode_t op;
    coord_t  start;
    coord_t  stop;
    logic    zero_val;
  } interval_req_t;

  // one line of the directed table: a register write or an input request
  typedef struct packed {
    row_kind_t     kind;
    cfg_idx_t      reg_idx;
    coord_t        reg_data;
    interval_req_t req;
    logic          typed;   // want is the known answer for this request
    result_t       want;
  } stim_row_t;

  localparam interval_req_t NoReq = '{OP_INTERVAL, '0, '0, 1'b0};
  localparam result_t       NoRes = '0;
  localparam int            DirRows = 34;

  // directed part: reset state, clean gaps, each error, clipping, both origins, extremes
  stim_row_t dir_rows [DirRows] = '{
    // straight after reset: length 0, finish gives nothing, any nonzero end is beyond
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, '0, '0, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, '0, Ones, 1'b0}, 1'b1,
      '{32'd0, 32'd0, 32'd0, ST_BEYOND}},
    // reject-beyond-end mode, 100 positions
    '{ROW_CFG, REG_REGION_LENGTH, 32'd100, NoReq, 1'b0, NoRes},
    '{ROW_CFG, REG_FILL_VALUE, Ones, NoReq, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd10, 32'd20, 1'b0}, 1'b1,
      '{32'd0, 32'd10, Ones, ST_FILL}},
    // abutting interval, empty gap
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd20, 32'd30, 1'b0}, 1'b0, NoRes},
    // zero-valued interval is ignored even though it overlaps
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd5, 32'd40, 1'b1}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd25, 32'd50, 1'b0}, 1'b1,
      '{32'd0, 32'd0, 32'd0, ST_ORDER}},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd60, 32'd101, 1'b0}, 1'b1,
      '{32'd0, 32'd0, 32'd0, ST_BEYOND}},
    // end below start is taken as given
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd60, 32'd55, 1'b0}, 1'b0, NoRes},
    // finish ignores its other fields
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, Ones, Ones, 1'b1}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd0, 32'd100, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, '0, '0, 1'b0}, 1'b0, NoRes},
    // origin-one, start of zero stays zero
    '{ROW_CFG, REG_ORIGIN_ONE, 32'd1, NoReq, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd0, 32'd8, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd11, 32'd12, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, '0, '0, 1'b0}, 1'b0, NoRes},
    // clip mode: offset 1000, 50 positions
    '{ROW_CFG, REG_REGION_OFFSET, 32'd1000, NoReq, 1'b0, NoRes},
    '{ROW_CFG, REG_REGION_LENGTH, 32'd50, NoReq, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd0, 32'd0, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd1001, 32'd1010, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd1021, 32'd1030, 1'b0}, 1'b0, NoRes},
    // starts past the region, dropped
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd1051, 32'd1060, 1'b0}, 1'b0, NoRes},
    // end clamped to the region length
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, 32'd1041, Ones, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, '0, '0, 1'b0}, 1'b0, NoRes},
    // finish on a fresh region fills the whole vector
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, '0, '0, 1'b0}, 1'b1,
      '{32'd0, 32'd50, Ones, ST_FILL}},
    // extremes of every register
    '{ROW_CFG, REG_REGION_OFFSET, Ones, NoReq, 1'b0, NoRes},
    '{ROW_CFG, REG_REGION_LENGTH, Ones, NoReq, 1'b0, NoRes},
    '{ROW_CFG, REG_ORIGIN_ONE, 32'd0, NoReq, 1'b0, NoRes},
    '{ROW_CFG, REG_FILL_VALUE, 32'd0, NoReq, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, Ones, Ones, 1'b0}, 1'b0, NoRes},
    '{ROW_CFG, REG_REGION_OFFSET, 32'd1, NoReq, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_INTERVAL, Ones, Ones, 1'b0}, 1'b0, NoRes},
    '{ROW_ITEM, REG_REGION_OFFSET, '0, '{OP_FINISH, '0, '0, 1'b0}, 1'b0, NoRes}
  };

  logic clk = 1'b0;
  logic rst_n;

  icgf_in_if  in_ch  ();
  icgf_out_if out_ch ();
  icgf_cfg_if cfg_ch ();

  interval_complement_gap_filler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_req(out_ch),
    .cfg_req(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and running end of the gap predictor
  coord_t reg_offset = '0;
  coord_t reg_length = '0;
  logic   reg_origin = 1'b0;
  coord_t reg_fill   = '0;
  coord_t run_end    = '0;

  // fill-range results still owed by the block, oldest first
  result_t fill_cmds_due [$];

  int requests_in  = 0;
  int results_out  = 0;
  int cfg_writes   = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  // idle rates in percent of cycles, changed between phases
  int   tx_idle_pct = 20;
  int   rx_idle_pct = 20;
  logic rx_hold     = 1'b0;
  event hold_off_go;

  // works out the result, if any, of one accepted request and advances the running end
  function automatic logic predict_fill(input interval_req_t rq, output result_t r);
    coord_t s, b, en, prev;
    r = '0;
    if (rq.op == OP_FINISH) begin
      // tail gap, then start over for the next region
      prev = run_end;
      run_end = '0;
      if (prev < reg_length) begin
        r = '{prev, reg_length, reg_fill, ST_FILL};
        return 1'b1;
      end
      return 1'b0;
    end
    if (rq.zero_val) return 1'b0;
    // origin-one start moves down by one, but zero does not wrap
    s = (reg_origin && rq.start != '0) ? rq.start - 32'd1 : rq.start;
    if (reg_offset == '0) begin
      if (rq.stop > reg_length) begin
        r.status = ST_BEYOND;
        return 1'b1;
      end
      b  = s;
      en = rq.stop;
    end else begin
      // shift onto the vector, drop what lies outside, clip the rest
      if (rq.stop <= reg_offset) return 1'b0;
      en = rq.stop - reg_offset;
      b  = (s <= reg_offset) ? '0 : s - reg_offset;
      if (b >= reg_length) return 1'b0;
      if (en > reg_length) en = reg_length;
    end
    if (b < run_end) begin
      r.status = ST_ORDER;
      return 1'b1;
    end
    prev = run_end;
    run_end = en;
    if (prev < b) begin
      r = '{prev, b, reg_fill, ST_FILL};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // offer one request, wait for it to be taken, then log what it owes
  task automatic send_item(input interval_req_t rq, input logic typed, input result_t want);
    int gap;
    result_t r;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= rq.op;
    in_ch.interval_start <= rq.start;
    in_ch.interval_end   <= rq.stop;
    in_ch.value_is_zero  <= rq.zero_val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_fill(rq, r)) fill_cmds_due.push_back(typed ? want : r);
    requests_in++;
  endtask

  // stop offering, let every owed result out, then let the pipe run dry
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (fill_cmds_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one register write; valid stays up when another write follows right away
  task automatic write_reg(input cfg_idx_t idx, input coord_t val, input logic last_one);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (last_one) cfg_ch.valid <= 1'b0;
    case (idx)
      REG_REGION_OFFSET: reg_offset = val;
      REG_REGION_LENGTH: reg_length = val;
      REG_ORIGIN_ONE:    reg_origin = val[0];
      REG_FILL_VALUE:    reg_fill   = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // pick a region: reject mode often, clip mode otherwise, extremes now and then
  task automatic setup_region();
    coord_t off, len, fill;
    case ($urandom_range(9))
      0, 1, 2: off = '0;
      3:       off = Ones;
      4:       off = 32'd1;
      default: off = $urandom_range(32'h7FFF_FFFF, 41);
    endcase
    case ($urandom_range(7))
      0:       len = '0;
      1:       len = Ones;
      default: len = $urandom_range(300, 1);
    endcase
    case ($urandom_range(5))
      0:       fill = '0;
      1:       fill = Ones;
      default: fill = $urandom;
    endcase
    settle();
    write_reg(REG_REGION_OFFSET, off, 1'b0);
    write_reg(REG_REGION_LENGTH, len, 1'b0);
    write_reg(REG_ORIGIN_ONE, $urandom, 1'b0);
    write_reg(REG_FILL_VALUE, fill, 1'b1);
  endtask

  // mostly sorted intervals with random gaps and lengths, some noise, then a finish
  task automatic run_region();
    interval_req_t rq;
    coord_t cur;
    int n;
    cur = (reg_offset > 40) ? reg_offset - $urandom_range(40) : '0;
    n = $urandom_range(12, 1);
    repeat (n) begin
      rq.op = OP_INTERVAL;
      rq.zero_val = ($urandom_range(7) == 0);
      case ($urandom_range(19))
        0: begin
          // anything at all
          rq.start    = $urandom;
          rq.stop     = $urandom;
          rq.zero_val = $urandom_range(1);
        end
        1: begin
          // steps back behind the running end
          rq.start = cur - $urandom_range(30, 1);
          rq.stop  = rq.start + $urandom_range(30);
        end
        2: begin
          // early finish in the middle of a region
          rq.op    = OP_FINISH;
          rq.start = $urandom;
          rq.stop  = $urandom;
        end
        default: begin
          if ($urandom_range(2) != 0) cur = cur + $urandom_range(20, 1);
          rq.start = cur + reg_origin;
          cur = cur + $urandom_range(25);
          rq.stop = cur;
        end
      endcase
      send_item(rq, 1'b0, NoRes);
    end
    rq.op       = OP_FINISH;
    rq.start    = $urandom;
    rq.stop     = $urandom;
    rq.zero_val = $urandom_range(1);
    send_item(rq, 1'b0, NoRes);
  endtask

  // result side ready, random per cycle, forced low during the hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long hold-off, counted here on the falling edge so it never races the driver
  initial begin
    forever begin
      @(hold_off_go);
      @(negedge clk);
      rx_hold = 1'b1;
      repeat (HoldCycles) @(negedge clk);
      rx_hold = 1'b0;
    end
  end

  // result checker: each accepted result against the oldest one owed
  always @(posedge clk) begin
    result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_out++;
      if (fill_cmds_due.size() == 0) begin
        $error("result with nothing owed: fill_begin %0d fill_end %0d status %0d",
               out_ch.fill_begin, out_ch.fill_end, out_ch.status);
        mismatches++;
      end else begin
        due = fill_cmds_due.pop_front();
        if (out_ch.fill_begin !== due.fill_begin) begin
          $error("fill_begin: expected %0d, got %0d", due.fill_begin, out_ch.fill_begin);
          mismatches++;
        end
        if (out_ch.fill_end !== due.fill_end) begin
          $error("fill_end: expected %0d, got %0d", due.fill_end, out_ch.fill_end);
          mismatches++;
        end
        if (out_ch.fill_data !== due.fill_data) begin
          $error("fill_data: expected %h, got %h", due.fill_data, out_ch.fill_data);
          mismatches++;
        end
        if (out_ch.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_ch.status);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no request moving anywhere means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL interval_complement_gap_filler");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // stimulus: reset, directed table, then three idle mixes of random regions
  initial begin
    int directed_in;
    int phase_start;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_INTERVAL;
    in_ch.interval_start <= '0;
    in_ch.interval_end   <= '0;
    in_ch.value_is_zero  <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_REGION_OFFSET;
    cfg_ch.data          <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        // registers change only with the block idle
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data,
                  i == DirRows - 1 || dir_rows[i+1].kind != ROW_CFG);
      end else begin
        send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    directed_in = requests_in;

    for (int ph = 0; ph < 3; ph++) begin
      // sender-light/receiver-heavy, then the reverse, then flat out
      tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 73 : 0;
      rx_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 38 : 0;
      phase_start = requests_in;
      setup_region();
      // flat out into a stalled receiver, so the block backs up onto its input
      if (ph == 2) -> hold_off_go;
      while (requests_in - phase_start < PhaseItems) begin
        if ($urandom_range(9) < 4) setup_region();
        run_region();
      end
    end
    settle();

    $display("covered %0d requests (%0d directed), %0d results, %0d register writes",
             requests_in, directed_in, results_out, cfg_writes);
    $display("three idle mixes and a %0d-cycle result hold-off, %0d mismatches",
             HoldCycles, mismatches);
    if (mismatches == 0) begin
      $display("PASS interval_complement_gap_filler");
    end else begin
      $display("FAIL interval_complement_gap_filler");
    end
    $finish;
  end

endmodule
